[rtl/core/at2o_pkg.sv]
`timescale 1ns / 1ps

package at2o_pkg;

  localparam int TABLE_STEPS_DEF = 1024;
  localparam int COORD_W         = 16;
  localparam int ANGLE_W         = 16;
  localparam int LUT_W           = 14;

  localparam logic signed [ANGLE_W-1:0] ANG_PI      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 16'sd12868;

  // signs of the inputs and which magnitude is larger pick the octant
  typedef struct packed {
    logic neg_y;
    logic neg_x;
    logic swap;   // |x| < |y|: ratio is |x|/|y|
    logic zero;   // larger magnitude is zero
  } octant_t;

  // restoring long division, elaboration-time only (table build)
  function automatic logic [95:0] udiv96(input logic [95:0] n, input logic [31:0] d);
    logic [95:0] q;
    logic [32:0] r;
    q = '0;
    r = '0;
    for (int b = 95; b >= 0; b--) begin
      r = {r[31:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(a * b / 2^60)
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // atan(i / steps) in Q2.13 rounded to nearest, Euler series in Q60
  function automatic logic [LUT_W-1:0] atan_entry(input int unsigned i,
                                                  input int unsigned steps);
    logic [63:0] den;
    logic [63:0] z;
    logic [63:0] w;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] acc;
    logic [95:0] q;
    den  = 64'(steps) * 64'(steps) + 64'(i) * 64'(i);
    q    = udiv96({32'd0, 64'(i) * 64'(i)} << 60, den[31:0]);
    z    = q[63:0];
    q    = udiv96({32'd0, 64'(i) * 64'(steps)} << 60, den[31:0]);
    w    = q[63:0];
    term = 64'd1 << 60;
    sum  = 64'd1 << 60;
    for (int n = 1; n < 100 && term != 64'd0; n++) begin
      term = mul_q60(term, z);
      q    = udiv96({32'd0, term} * 96'(2 * n), 32'(2 * n + 1));
      term = q[63:0];
      sum  = sum + term;
    end
    acc = (mul_q60(w, sum) + (64'd1 << 46)) >> 47;
    return acc[LUT_W-1:0];
  endfunction

  // fold the table angle back into the full circle
  function automatic logic signed [ANGLE_W-1:0] angle_combine(input octant_t oct,
                                                              input logic [LUT_W-1:0] lut);
    logic signed [ANGLE_W-1:0] l;
    logic signed [ANGLE_W-1:0] r;
    l = signed'(ANGLE_W'(lut));
    case ({oct.neg_y, oct.neg_x})
      2'b00:   r = oct.swap ? ANG_HALF_PI - l : l;
      2'b01:   r = oct.swap ? l + ANG_HALF_PI : ANG_PI - l;
      2'b11:   r = oct.swap ? -ANG_HALF_PI - l : l - ANG_PI;
      default: r = oct.swap ? l - ANG_HALF_PI : -l;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/at2o_ifs.sv]
`timescale 1ns / 1ps

interface at2o_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [at2o_pkg::COORD_W-1:0] coord_y;
  logic signed [at2o_pkg::COORD_W-1:0] coord_x;

  modport source (output valid, output coord_y, output coord_x, input ready);
  modport sink   (input valid, input coord_y, input coord_x, output ready);
endinterface

interface at2o_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [at2o_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

[rtl/core/at2o_ram.sv]
`timescale 1ns / 1ps

module at2o_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/at2o_div_cell.sv]
`timescale 1ns / 1ps

module at2o_div_cell #(
  parameter int NW  = 27,
  parameter int DW  = 17,
  parameter int QW  = 11,
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NW-1:0]     in_rem,
  input  logic [DW-1:0]     in_div,
  input  logic [QW-1:0]     in_quo,
  input  at2o_pkg::octant_t in_oct,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NW-1:0]     out_rem,
  output logic [DW-1:0]     out_div,
  output logic [QW-1:0]     out_quo,
  output at2o_pkg::octant_t out_oct
);

  localparam int EW = NW + QW;

  logic              valid_r;
  logic [NW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     div_r;
  logic [QW-1:0]     quo_r, quo_nxt;
  at2o_pkg::octant_t oct_r;
  logic [EW-1:0]     rem_ext, div_sh, diff;
  logic              take;

  // one restoring step: try the divisor at this quotient weight
  always_comb begin
    rem_ext      = EW'(in_rem);
    div_sh       = EW'(in_div) << BIT;
    take         = rem_ext >= div_sh;
    diff         = rem_ext - div_sh;
    rem_nxt      = take ? diff[NW-1:0] : in_rem;
    quo_nxt      = in_quo;
    quo_nxt[BIT] = take;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r <= rem_nxt;
      div_r <= in_div;
      quo_r <= quo_nxt;
      oct_r <= in_oct;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_quo   = quo_r;
  assign out_oct   = oct_r;

endmodule

[rtl/core/at2o_rom_stage.sv]
`timescale 1ns / 1ps

module at2o_rom_stage #(
  parameter int TABLE_STEPS = at2o_pkg::TABLE_STEPS_DEF,
  parameter int QW          = $clog2(TABLE_STEPS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         fill_busy,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [QW-1:0]                in_quo,
  input  at2o_pkg::octant_t            in_oct,
  output logic                         out_valid,
  input  logic                         out_ready,
  output at2o_pkg::octant_t            out_oct,
  output logic [at2o_pkg::LUT_W-1:0]   out_lut
);

  localparam int DEPTH = TABLE_STEPS + 1;

  logic [at2o_pkg::LUT_W-1:0] atan_tab [0:DEPTH-1];

  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    localparam logic [at2o_pkg::LUT_W-1:0] ENTRY =
      at2o_pkg::atan_entry(g, TABLE_STEPS);
    assign atan_tab[g] = ENTRY;
  end

  logic              fill_busy_r;
  logic [QW-1:0]     fill_cnt_r;
  logic              valid_r;
  at2o_pkg::octant_t oct_r;
  logic [QW-1:0]     rd_addr;

  // table load sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_busy_r <= 1'b1;
      fill_cnt_r  <= '0;
    end else if (fill_busy_r) begin
      fill_cnt_r <= fill_cnt_r + QW'(1);
      if (fill_cnt_r == QW'(TABLE_STEPS)) begin
        fill_busy_r <= 1'b0;
      end
    end
  end

  assign fill_busy = fill_busy_r;
  assign in_ready  = !valid_r || out_ready;
  // zero divisor leaves a meaningless quotient; entry 0 reads as zero angle
  assign rd_addr   = in_oct.zero ? '0 : in_quo;

  at2o_ram #(
    .WIDTH (at2o_pkg::LUT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (fill_busy_r),
    .wr_addr (fill_cnt_r),
    .wr_data (atan_tab[fill_cnt_r]),
    .rd_en   (in_ready),
    .rd_addr (rd_addr),
    .rd_data (out_lut)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      oct_r <= in_oct;
    end
  end

  assign out_valid = valid_r;
  assign out_oct   = oct_r;

endmodule

[rtl/core/table_atan2_octant_core.sv]
`timescale 1ns / 1ps

// channel | dir | fields                   | transfer when
// in_ch   | in  | coord_y s16, coord_x s16 | valid && ready
// out_ch  | out | angle s16 (Q2.13 rad)    | valid && ready
//
// one transfer per cycle sustained while out_ch.ready stays high; stages in order:
// input register, one divider cell per quotient bit, table read, output
// register.
// after reset all TABLE_STEPS+1 (1025) arctan table entries are loaded
// with in_ch.ready low.
// every stage holds its item while the next is full; ready ripples back.

module table_atan2_octant_core #(
  parameter int TABLE_STEPS = at2o_pkg::TABLE_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  at2o_in_if.sink          in_ch,
  at2o_out_if.source       out_ch
);

  localparam int QW = $clog2(TABLE_STEPS + 1);
  localparam int DW = at2o_pkg::COORD_W + 1;
  localparam int NW = at2o_pkg::COORD_W + 1 + $clog2(TABLE_STEPS);

  logic              c_valid [0:QW];
  logic              c_ready [0:QW];
  logic [NW-1:0]     c_rem   [0:QW];
  logic [DW-1:0]     c_div   [0:QW];
  logic [QW-1:0]     c_quo   [0:QW];
  at2o_pkg::octant_t c_oct   [0:QW];

  // front stage: magnitudes, octant, dividend and divisor
  logic [at2o_pkg::COORD_W-1:0] ay, ax, mn, mx;
  at2o_pkg::octant_t            oct_nxt;
  logic [NW-1:0]                num_nxt;
  logic [DW-1:0]                den_nxt;
  logic                         v0_r;
  logic [NW-1:0]                num0_r;
  logic [DW-1:0]                den0_r;
  at2o_pkg::octant_t            oct0_r;
  logic                         fill_busy;
  logic                         front_ready;

  always_comb begin
    ay            = in_ch.coord_y[at2o_pkg::COORD_W-1] ? 16'(~in_ch.coord_y + 16'sd1)
                                                       : 16'(in_ch.coord_y);
    ax            = in_ch.coord_x[at2o_pkg::COORD_W-1] ? 16'(~in_ch.coord_x + 16'sd1)
                                                       : 16'(in_ch.coord_x);
    oct_nxt.neg_y = in_ch.coord_y[at2o_pkg::COORD_W-1];
    oct_nxt.neg_x = in_ch.coord_x[at2o_pkg::COORD_W-1];
    oct_nxt.swap  = ax < ay;
    mn            = oct_nxt.swap ? ax : ay;
    mx            = oct_nxt.swap ? ay : ax;
    oct_nxt.zero  = mx == '0;
    // rounded ratio: (2*min*steps + max) / (2*max)
    num_nxt       = (NW'(mn) << 1) * NW'(TABLE_STEPS) + NW'(mx);
    den_nxt       = {mx, 1'b0};
  end

  assign front_ready = !v0_r || c_ready[0];
  assign in_ch.ready = !fill_busy && front_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (front_ready) begin
      v0_r <= in_ch.valid && !fill_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (front_ready) begin
      num0_r <= num_nxt;
      den0_r <= den_nxt;
      oct0_r <= oct_nxt;
    end
  end

  assign c_valid[0] = v0_r;
  assign c_rem[0]   = num0_r;
  assign c_div[0]   = den0_r;
  assign c_quo[0]   = '0;
  assign c_oct[0]   = oct0_r;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    at2o_div_cell #(
      .NW  (NW),
      .DW  (DW),
      .QW  (QW),
      .BIT (QW - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[k]),
      .in_ready  (c_ready[k]),
      .in_rem    (c_rem[k]),
      .in_div    (c_div[k]),
      .in_quo    (c_quo[k]),
      .in_oct    (c_oct[k]),
      .out_valid (c_valid[k+1]),
      .out_ready (c_ready[k+1]),
      .out_rem   (c_rem[k+1]),
      .out_div   (c_div[k+1]),
      .out_quo   (c_quo[k+1]),
      .out_oct   (c_oct[k+1])
    );
  end

  logic                       rom_valid;
  logic                       rom_ready;
  at2o_pkg::octant_t          rom_oct;
  logic [at2o_pkg::LUT_W-1:0] rom_lut;

  at2o_rom_stage #(
    .TABLE_STEPS (TABLE_STEPS),
    .QW          (QW)
  ) u_rom (
    .clk       (clk),
    .rst_n     (rst_n),
    .fill_busy (fill_busy),
    .in_valid  (c_valid[QW]),
    .in_ready  (c_ready[QW]),
    .in_quo    (c_quo[QW]),
    .in_oct    (c_oct[QW]),
    .out_valid (rom_valid),
    .out_ready (rom_ready),
    .out_oct   (rom_oct),
    .out_lut   (rom_lut)
  );

  // output register
  logic                               out_valid_r;
  logic signed [at2o_pkg::ANGLE_W-1:0] angle_r;

  assign rom_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rom_ready) begin
      out_valid_r <= rom_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rom_ready) begin
      angle_r <= at2o_pkg::angle_combine(rom_oct, rom_lut);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.angle = angle_r;

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int COORD_W     = at2o_pkg::COORD_W;
  localparam int ANGLE_W     = at2o_pkg::ANGLE_W;
  localparam int LUT_W       = at2o_pkg::LUT_W;
  localparam int STEPS       = at2o_pkg::TABLE_STEPS_DEF;
  localparam int PI_Q13      = int'(at2o_pkg::ANG_PI);
  localparam int HALF_PI_Q13 = int'(at2o_pkg::ANG_HALF_PI);
  localparam int RANDOM_N    = 930;
  localparam int LATE_SPAN   = 150;
  localparam int HOLD_AT     = 200;   // results seen before the long hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT    = 600;   // transfers before the sender waits for drain
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } coord_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  at2o_in_if  in_ch ();
  at2o_out_if out_ch ();

  table_atan2_octant_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  logic [LUT_W-1:0]          arctan_q13 [0:STEPS];
  coord_pair_t               pending_pairs [$];
  logic signed [ANGLE_W-1:0] expected_angles [$];

  int total_items;
  int directed_items;
  int sent_count;
  int seen_count;
  int error_count;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;
  bit drain_done;
  int cycle_count;

  // atan(i/STEPS) in Q2.13 via Euler series in Q60, exact integer steps
  function automatic logic [LUT_W-1:0] atan_q13(input int unsigned i);
    logic [127:0] den;
    logic [127:0] z;
    logic [127:0] w;
    logic [127:0] term;
    logic [127:0] sum;
    logic [127:0] acc;
    den  = 128'(STEPS) * 128'(STEPS) + 128'(i) * 128'(i);
    z    = ((128'(i) * 128'(i)) << 60) / den;
    w    = ((128'(i) * 128'(STEPS)) << 60) / den;
    term = 128'd1 << 60;
    sum  = 128'd1 << 60;
    for (int n = 1; n < 100 && term != 0; n++) begin
      term = (term * z) >> 60;
      term = (term * 128'(2 * n)) / 128'(2 * n + 1);
      sum  = sum + term;
    end
    acc = (((w * sum) >> 60) + (128'd1 << 46)) >> 47;
    return acc[LUT_W-1:0];
  endfunction

  // rounded ratio num/den into the table; zero when den is zero
  function automatic int table_angle(input int num, input int den);
    int idx;
    if (den == 0) return 0;
    idx = (2 * num * STEPS + den) / (2 * den);
    if (idx > STEPS) idx = STEPS;
    return int'(arctan_q13[idx]);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] predict_angle(
    input logic signed [COORD_W-1:0] cy, input logic signed [COORD_W-1:0] cx);
    int y;
    int x;
    int ay;
    int ax;
    int r;
    y  = int'(cy);
    x  = int'(cx);
    ay = (y < 0) ? -y : y;
    ax = (x < 0) ? -x : x;
    if (y >= 0) begin
      if (x >= 0) begin
        r = (ax >= ay) ? table_angle(ay, ax) : HALF_PI_Q13 - table_angle(ax, ay);
      end else begin
        r = (ax < ay) ? table_angle(ax, ay) + HALF_PI_Q13
                      : PI_Q13 - table_angle(ay, ax);
      end
    end else begin
      if (x < 0) begin
        r = (ax >= ay) ? table_angle(ay, ax) - PI_Q13
                       : -HALF_PI_Q13 - table_angle(ax, ay);
      end else begin
        r = (ax < ay) ? table_angle(ax, ay) - HALF_PI_Q13 : -table_angle(ay, ax);
      end
    end
    return ANGLE_W'(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] with_sign(input int mag, input bit neg);
    if (neg) return COORD_W'(-mag);
    return COORD_W'((mag > 32767) ? 32767 : mag);
  endfunction

  task automatic queue_pair(input int y, input int x);
    coord_pair_t p;
    p.y = COORD_W'(y);
    p.x = COORD_W'(x);
    pending_pairs.push_back(p);
  endtask

  // sender
  always @(posedge clk) begin
    coord_pair_t p;
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.coord_y <= '0;
      in_ch.coord_x <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_angles.push_back(predict_angle(in_ch.coord_y, in_ch.coord_x));
        sent_count++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (sent_count == DRAIN_AT && !drain_done && expected_angles.size() == 0)
          drain_done = 1'b1;
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_pairs.size() == 0 || (sent_count == DRAIN_AT && !drain_done)) begin
          in_ch.valid <= 1'b0;
        end else if (sent_count < total_items - LATE_SPAN && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_ch.valid <= 1'b0;
        end else begin
          p = pending_pairs.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.coord_y <= p.y;
          in_ch.coord_x <= p.x;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic signed [ANGLE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_count++;
        if (expected_angles.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected angle %0d with nothing outstanding", out_ch.angle);
        end else begin
          want = expected_angles.pop_front();
          if (out_ch.angle !== want) begin
            error_count++;
            if (error_count <= 10)
              $display("angle mismatch on result %0d: expected %0d, got %0d",
                       seen_count, want, out_ch.angle);
          end
        end
      end
      if (seen_count >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (seen_count < total_items - LATE_SPAN && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int mode;
    int m;
    int d;
    in_ch.valid   = 1'b0;
    in_ch.coord_y = '0;
    in_ch.coord_x = '0;
    out_ch.ready  = 1'b0;
    rst_n = 1'b0;
    for (int i = 0; i <= STEPS; i++)
      arctan_q13[i] = atan_q13(i);

    // axes, corners, equal magnitudes in every quadrant, tiny and huge ratios
    queue_pair(0, 0);
    queue_pair(32767, 0);
    queue_pair(0, 32767);
    queue_pair(-32768, 0);
    queue_pair(0, -32768);
    queue_pair(0, -5);
    queue_pair(32767, 32767);
    queue_pair(-32768, -32768);
    queue_pair(-32768, 32767);
    queue_pair(32767, -32768);
    queue_pair(100, 100);
    queue_pair(100, -100);
    queue_pair(-100, -100);
    queue_pair(-100, 100);
    queue_pair(1, 32767);
    queue_pair(32767, 1);
    queue_pair(-1, -32768);
    queue_pair(-32768, -1);
    queue_pair(1, 1);
    queue_pair(-1, -1);
    queue_pair(3, 7);
    queue_pair(-7, 3);
    queue_pair(-32768, 32768 - 1);
    queue_pair(32767, -32767);
    directed_items = pending_pairs.size();

    for (int i = 0; i < RANDOM_N; i++) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2, 3: begin
          queue_pair(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        end
        4, 5: begin
          queue_pair(with_sign($urandom_range(0, 64), $urandom_range(0, 1)),
                     with_sign($urandom_range(0, 64), $urandom_range(0, 1)));
        end
        6: begin
          // near the octant boundaries
          m = $urandom_range(1, 32768);
          d = $urandom_range(0, 3);
          if ($urandom_range(0, 1))
            queue_pair(with_sign(m, $urandom_range(0, 1)),
                       with_sign((m > d) ? m - d : m, $urandom_range(0, 1)));
          else
            queue_pair(with_sign((m > d) ? m - d : m, $urandom_range(0, 1)),
                       with_sign(m, $urandom_range(0, 1)));
        end
        7: begin
          if ($urandom_range(0, 1))
            queue_pair(0, int'($signed(16'($urandom))));
          else
            queue_pair(int'($signed(16'($urandom))), 0);
        end
        8: begin
          m = $urandom_range(0, 4);
          d = $urandom_range(0, 4);
          queue_pair((m == 0) ? -32768 : (m == 1) ? 32767 : m - 3,
                     (d == 0) ? -32768 : (d == 1) ? 32767 : d - 3);
        end
        default: begin
          if ($urandom_range(0, 1))
            queue_pair(with_sign($urandom_range(0, 40), $urandom_range(0, 1)),
                       int'($signed(16'($urandom))));
          else
            queue_pair(int'($signed(16'($urandom))),
                       with_sign($urandom_range(0, 40), $urandom_range(0, 1)));
        end
      endcase
    end
    total_items = pending_pairs.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_items || expected_angles.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (expected_angles.size() != 0) begin
      error_count += expected_angles.size();
      $display("%0d angles never arrived", expected_angles.size());
    end

    $display("covered %0d coordinate pairs (%0d directed), %0d angles checked",
             total_items, directed_items, seen_count);
    $display("with a %0d-cycle output hold-off and a full drain at transfer %0d",
             HOLD_CYCLES, DRAIN_AT);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[table_atan2_octant_core.f]
rtl/core/at2o_pkg.sv
rtl/core/at2o_ifs.sv
rtl/core/at2o_ram.sv
rtl/core/at2o_div_cell.sv
rtl/core/at2o_rom_stage.sv
rtl/core/table_atan2_octant_core.sv
sim/tb.sv
